@@ design/kbpr_pkg.sv @@
// ----------------------------------------------------------------------------
// kbpr_pkg
// Shared types, constants and the key code map of the keypad bus responder.
// ----------------------------------------------------------------------------
package kbpr_pkg;

  localparam int MAX_PACKET_BYTES_DEF = 40;
  localparam int KEY_QUEUE_DEPTH_DEF  = 10;

  localparam int LEN_W = 6;

  localparam logic [3:0] HDR_BASE   = 4'h2;
  localparam logic [7:0] LINE_RESET = 8'hFF;
  localparam logic [7:0] NO_KEY     = 8'hFF;
  localparam int ACK_BIT   = 2;
  localparam int WARN_BIT  = 2;
  localparam int ALARM_BIT = 1;

  localparam logic [3:0] CODE_ZERO    = 4'hA;
  localparam logic [3:0] CODE_STAR    = 4'hB;
  localparam logic [3:0] CODE_HASH    = 4'hC;
  localparam logic [3:0] CODE_PROG    = 4'hD;
  localparam logic [3:0] CODE_UNKNOWN = 4'hE;
  localparam logic [3:0] CODE_ENTER   = 4'hF;

  typedef struct packed {
    logic good;
    logic cserr;
    logic ovf;
    logic wrise;
    logic arise;
    logic drop;
  } evt_t;

  typedef struct packed {
    logic       reply;
    logic [7:0] h1;
    logic [7:0] h2;
    logic [7:0] csum;
    evt_t       evt;
  } job_t;

  function automatic logic [3:0] map_key(input logic [7:0] k);
    logic [3:0] code;
    code = CODE_UNKNOWN;
    if (k >= 8'h31 && k <= 8'h39) code = 4'(k - 8'h30);
    else if (k == 8'h30) code = CODE_ZERO;
    else if (k == 8'h66 || k == 8'h2a) code = CODE_STAR;
    else if (k == 8'h76 || k == 8'h23) code = CODE_HASH;
    else if (k == 8'h70) code = CODE_PROG;
    else if (k == 8'h0d || k == 8'h2b || k == 8'h79 || k == 8'h59) code = CODE_ENTER;
    return code;
  endfunction

endpackage

@@ design/kbpr_front.sv @@
// ----------------------------------------------------------------------------
// kbpr_front
// Accepts line bytes and key pushes, frames and checks packets, keeps the
// key queue and issues one job per accepted word.
// ----------------------------------------------------------------------------
module kbpr_front
  import kbpr_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF,
  parameter int KEY_QUEUE_DEPTH  = KEY_QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       command,
  input  logic [7:0] data,
  input  logic       cfg_valid,
  input  logic [3:0] device_id,
  output logic       job_push,
  output job_t       job,
  input  logic       job_ready
);

  localparam int IW = (KEY_QUEUE_DEPTH > 1) ? $clog2(KEY_QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(KEY_QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;

  logic [3:0]       dev;
  logic             in_packet, in_packet_next;
  logic [7:0]       prev, prev_next;
  logic [LEN_W-1:0] len, len_next;
  logic [7:0]       header, header_next;
  logic [7:0]       status, status_next;
  logic [7:0]       bbl, bbl_next;
  logic [7:0]       sum, sum_next;
  logic [7:0]       last_code, last_code_next;
  logic             warn_seen, warn_seen_next;
  logic             alarm_seen, alarm_seen_next;
  logic [7:0]       key_queue [KEY_QUEUE_DEPTH];
  logic [7:0]       head_key;
  logic [CW-1:0]    key_count, key_count_next;
  logic [IW-1:0]    key_head, key_head_next;
  logic [SW-1:0]    tail_sum;
  logic [IW-1:0]    tail;
  logic             push_key, pop_key;
  logic [7:0]       chk;

  assign in_ready = job_ready;
  assign job_push = in_valid && in_ready;

  assign tail_sum = SW'(key_head) + SW'(key_count);
  assign tail = (tail_sum >= SW'(KEY_QUEUE_DEPTH)) ? IW'(tail_sum - SW'(KEY_QUEUE_DEPTH))
                                                   : IW'(tail_sum);

  always_comb begin
    in_packet_next  = in_packet;
    prev_next       = prev;
    len_next        = len;
    header_next     = header;
    status_next     = status;
    bbl_next        = bbl;
    sum_next        = sum;
    last_code_next  = last_code;
    warn_seen_next  = warn_seen;
    alarm_seen_next = alarm_seen;
    push_key        = 1'b0;
    pop_key         = 1'b0;
    chk             = (sum == 8'd0) ? 8'd1 : sum;
    job             = '0;
    if (command) begin
      if (key_count < CW'(KEY_QUEUE_DEPTH)) begin
        push_key = 1'b1;
      end else begin
        job.evt.drop = 1'b1;
      end
    end else if (!in_packet) begin
      if (prev == 8'd0 && data != 8'd0) begin
        in_packet_next = 1'b1;
        len_next       = LEN_W'(1);
        header_next    = data;
        status_next    = 8'd0;
        sum_next       = 8'd0;
        bbl_next       = data;
      end
      prev_next = data;
    end else begin
      prev_next   = data;
      status_next = (len == LEN_W'(1)) ? data : status;
      sum_next    = sum + bbl;
      bbl_next    = data;
      len_next    = len + LEN_W'(1);
      if (data != 8'd0) begin
        if (len_next >= LEN_W'(MAX_PACKET_BYTES)) begin
          in_packet_next = 1'b0;
          job.evt.ovf    = 1'b1;
        end
      end else begin
        in_packet_next = 1'b0;
        if (chk != bbl) begin
          job.evt.cserr = 1'b1;
        end else begin
          job.evt.good = 1'b1;
          if (header[7:4] == dev) begin
            job.reply = 1'b1;
            job.h1    = {dev, HDR_BASE};
            if (header[ACK_BIT]) begin
              if (key_count != '0) begin
                pop_key = 1'b1;
                job.h2  = {map_key(head_key), 4'h0};
              end
              last_code_next = job.h2;
            end else begin
              job.h2 = (last_code == NO_KEY) ? 8'd0 : last_code;
            end
            job.csum = job.h1 + job.h2;
          end
          job.evt.wrise   = status_next[WARN_BIT] && !warn_seen;
          job.evt.arise   = status_next[ALARM_BIT] && !alarm_seen;
          warn_seen_next  = status_next[WARN_BIT];
          alarm_seen_next = status_next[ALARM_BIT];
        end
      end
    end
    key_count_next = key_count;
    key_head_next  = key_head;
    if (push_key) key_count_next = key_count + CW'(1);
    if (pop_key) begin
      key_count_next = key_count - CW'(1);
      key_head_next  = (key_head == IW'(KEY_QUEUE_DEPTH - 1)) ? '0 : key_head + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dev        <= '0;
      in_packet  <= 1'b0;
      prev       <= LINE_RESET;
      len        <= '0;
      header     <= '0;
      status     <= '0;
      bbl        <= '0;
      sum        <= '0;
      last_code  <= NO_KEY;
      warn_seen  <= 1'b0;
      alarm_seen <= 1'b0;
      key_count  <= '0;
      key_head   <= '0;
    end else begin
      if (cfg_valid) dev <= device_id;
      if (job_push) begin
        in_packet  <= in_packet_next;
        prev       <= prev_next;
        len        <= len_next;
        header     <= header_next;
        status     <= status_next;
        bbl        <= bbl_next;
        sum        <= sum_next;
        last_code  <= last_code_next;
        warn_seen  <= warn_seen_next;
        alarm_seen <= alarm_seen_next;
        key_count  <= key_count_next;
        key_head   <= key_head_next;
      end
    end
  end

  // head entry kept registered, new key bypassed into an empty queue
  always_ff @(posedge clk) begin
    if (job_push && push_key) key_queue[tail] <= data;
    if (job_push) begin
      if (push_key && tail == key_head_next) head_key <= data;
      else head_key <= key_queue[key_head_next];
    end
  end

endmodule

@@ design/kbpr_fifo.sv @@
// ----------------------------------------------------------------------------
// kbpr_fifo
// Two-entry job queue between the front and back halves.
// ----------------------------------------------------------------------------
module kbpr_fifo
  import kbpr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t din,
  output logic ready,
  output logic valid,
  output job_t dout,
  input  logic pop
);

  job_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign ready = (count != 2'd2);
  assign valid = (count != 2'd0);
  assign dout  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= din;
  end

endmodule

@@ design/kbpr_back.sv @@
// ----------------------------------------------------------------------------
// kbpr_back
// Takes jobs from the queue and sends their result words, one a cycle while
// out_ready does not stall them, through a registered output stage.
// ----------------------------------------------------------------------------
module kbpr_back
  import kbpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  input  job_t       job,
  output logic       job_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       has_reply,
  output logic [7:0] reply_byte,
  output logic       last,
  output evt_t       evt
);

  job_t       cur;
  logic       act;
  logic [1:0] beat;
  logic       load;
  logic       is_last;
  logic [7:0] beat_byte;

  assign load    = act && (!out_valid || out_ready);
  assign is_last = !cur.reply || (beat == 2'd3);
  assign job_pop = job_valid && (!act || (load && is_last));

  always_comb begin
    case (beat)
      2'd0:    beat_byte = cur.h1;
      2'd1:    beat_byte = cur.h2;
      2'd3:    beat_byte = cur.csum;
      default: beat_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act       <= 1'b0;
      beat      <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (job_pop) begin
        act  <= 1'b1;
        beat <= 2'd0;
      end else if (load) begin
        if (is_last) act <= 1'b0;
        else beat <= beat + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) cur <= job;
    if (load) begin
      has_reply  <= cur.reply;
      reply_byte <= cur.reply ? beat_byte : 8'd0;
      last       <= is_last;
      evt        <= (beat == 2'd0) ? cur.evt : '0;
    end
  end

endmodule

@@ design/keypad_bus_packet_responder.sv @@
// ----------------------------------------------------------------------------
// keypad_bus_packet_responder
// Keypad bus responder: packet framing and checking up front, reply words
// sent from a sequencer behind a two-entry job queue.
// ----------------------------------------------------------------------------
// path: accepted input word -> job queue -> back sequencer -> registered outputs
// throughput: one input word a cycle while the job queue has room; a reply
//   is four result words, sent by the back sequencer one a cycle unless stalled
// reset: synchronous rst clears framing, flags, key count and the queues;
//   key queue entries hold no value until written
module keypad_bus_packet_responder
  import kbpr_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF,
  parameter int KEY_QUEUE_DEPTH  = KEY_QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       command,
  input  logic [7:0] data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] device_id,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       has_reply,
  output logic [7:0] reply_byte,
  output logic       last,
  output logic       packet_good,
  output logic       checksum_error,
  output logic       overflow,
  output logic       warning_rise,
  output logic       alarm_rise,
  output logic       key_dropped
);

  job_t fj;
  job_t bj;
  logic fj_push;
  logic fj_ready;
  logic bj_valid;
  logic bj_pop;
  evt_t evt;

  assign cfg_ready = 1'b1;

  kbpr_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES),
    .KEY_QUEUE_DEPTH (KEY_QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .data     (data),
    .cfg_valid(cfg_valid),
    .device_id(device_id),
    .job_push (fj_push),
    .job      (fj),
    .job_ready(fj_ready)
  );

  kbpr_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (fj_push),
    .din  (fj),
    .ready(fj_ready),
    .valid(bj_valid),
    .dout (bj),
    .pop  (bj_pop)
  );

  kbpr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (bj_valid),
    .job       (bj),
    .job_pop   (bj_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .has_reply (has_reply),
    .reply_byte(reply_byte),
    .last      (last),
    .evt       (evt)
  );

  assign packet_good    = evt.good;
  assign checksum_error = evt.cserr;
  assign overflow       = evt.ovf;
  assign warning_rise   = evt.wrise;
  assign alarm_rise     = evt.arise;
  assign key_dropped    = evt.drop;

endmodule

@@ design/kbpr_checker.sv @@
// ----------------------------------------------------------------------------
// kbpr_checker
// Port-level checks on the result stream of the keypad bus responder.
// ----------------------------------------------------------------------------
module kbpr_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       has_reply,
  input logic [7:0] reply_byte,
  input logic       last,
  input logic       packet_good,
  input logic       checksum_error,
  input logic       overflow,
  input logic       warning_rise,
  input logic       alarm_rise,
  input logic       key_dropped
);

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(reply_byte) && $stable(last)
      && $stable(has_reply))
    else $error("result word changed while stalled");

  a_plain: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_reply |-> last && reply_byte == 8'd0)
    else $error("word without reply is not a single last word");

  a_events: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({packet_good, checksum_error, overflow, key_dropped}))
    else $error("conflicting event flags");

  a_rise: assert property (@(posedge clk) disable iff (rst)
    out_valid && (warning_rise || alarm_rise) |-> packet_good)
    else $error("status rise without good packet");

  a_reply_good: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_reply && (packet_good || checksum_error || overflow || key_dropped)
      |-> packet_good)
    else $error("reply without good packet");

endmodule

bind keypad_bus_packet_responder kbpr_checker u_chk (.*);

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keypad bus responder. Panel line words and host
// key pushes go in through a valid/ready channel with random gaps. A local
// model of the framing, checksum, reply and key queue predicts every result
// word, and the result words are taken with random stalls and compared field
// by field in order. Directed cases come first, then random framed traffic
// over several device addresses.
// ----------------------------------------------------------------------------
module tb_top
  import kbpr_pkg::*;
();

  localparam int LIMIT = 500000;

  typedef struct packed {
    logic       has_reply;
    logic [7:0] reply_byte;
    logic       last;
    logic       packet_good;
    logic       checksum_error;
    logic       overflow;
    logic       warning_rise;
    logic       alarm_rise;
    logic       key_dropped;
  } resp_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic       command;
  logic [7:0] data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [3:0] device_id;
  logic       out_valid;
  logic       out_ready;
  logic       has_reply;
  logic [7:0] reply_byte;
  logic       last;
  logic       packet_good;
  logic       checksum_error;
  logic       overflow;
  logic       warning_rise;
  logic       alarm_rise;
  logic       key_dropped;

  // local copy of the responder state
  logic       lb_in_frame;
  logic [7:0] lb_prev;
  logic [5:0] lb_count;
  logic [7:0] lb_header;
  logic [7:0] lb_status;
  logic [7:0] lb_tail;
  logic [7:0] lb_sum;
  logic [7:0] last_code;
  logic       warn_seen;
  logic       alarm_seen;
  logic [7:0] key_fifo [KEY_QUEUE_DEPTH_DEF];
  int         key_fill;
  int         key_rd;
  logic [3:0] dev_addr;

  resp_t      resp_due [$];
  resp_t      want;
  logic [7:0] frame [$];
  int         errors;
  int         useful;
  int         cycles;
  int         in_calm;
  int         out_calm;
  string      key_chars;

  keypad_bus_packet_responder DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .data           (data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .device_id      (device_id),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .has_reply      (has_reply),
    .reply_byte     (reply_byte),
    .last           (last),
    .packet_good    (packet_good),
    .checksum_error (checksum_error),
    .overflow       (overflow),
    .warning_rise   (warning_rise),
    .alarm_rise     (alarm_rise),
    .key_dropped    (key_dropped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic logic [3:0] key_nibble(input logic [7:0] k);
    if (k >= "1" && k <= "9") return k[3:0];
    case (k)
      "0":                   return CODE_ZERO;
      "f", "*":              return CODE_STAR;
      "v", "#":              return CODE_HASH;
      "p":                   return CODE_PROG;
      8'h0d, "+", "y", "Y":  return CODE_ENTER;
      default:               return CODE_UNKNOWN;
    endcase
  endfunction

  function automatic int draw_wait(input int calm);
    if (calm > 0) return 0;
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  function automatic int next_calm(input int calm);
    if (calm > 0) return calm - 1;
    if ($urandom_range(0, 24) == 0) return $urandom_range(8, 30);
    return 0;
  endfunction

  task automatic take_byte(input logic [7:0] b);
    if (lb_count == 6'd1) lb_status = b;
    lb_sum   = lb_sum + lb_tail;
    lb_tail  = b;
    lb_count = lb_count + 6'd1;
  endtask

  task automatic respond_to(input logic cmd, input logic [7:0] d);
    logic       good, cserr, ovf, wrise, arise, drop, reply;
    logic       w, a;
    logic [7:0] chk, total, code, head;
    resp_t      e;
    int         n;
    good  = 1'b0;
    cserr = 1'b0;
    ovf   = 1'b0;
    wrise = 1'b0;
    arise = 1'b0;
    drop  = 1'b0;
    reply = 1'b0;
    code  = 8'h00;
    head  = {dev_addr, HDR_BASE};
    if (cmd) begin
      if (key_fill < KEY_QUEUE_DEPTH_DEF) begin
        key_fifo[(key_rd + key_fill) % KEY_QUEUE_DEPTH_DEF] = d;
        key_fill++;
      end else begin
        drop = 1'b1;
      end
    end else if (!lb_in_frame) begin
      if (lb_prev == 8'h00 && d != 8'h00) begin
        lb_in_frame = 1'b1;
        lb_count    = 6'd1;
        lb_header   = d;
        lb_status   = 8'h00;
        lb_sum      = 8'h00;
        lb_tail     = d;
      end
      lb_prev = d;
    end else begin
      lb_prev = d;
      if (d != 8'h00) begin
        take_byte(d);
        if (int'(lb_count) >= MAX_PACKET_BYTES_DEF) begin
          lb_in_frame = 1'b0;
          ovf = 1'b1;
        end
      end else begin
        lb_in_frame = 1'b0;
        chk   = lb_tail;
        total = lb_sum;
        take_byte(8'h00);
        if (total == 8'h00) total = 8'h01;
        if (total != chk) begin
          cserr = 1'b1;
        end else begin
          w    = lb_status[WARN_BIT];
          a    = lb_status[ALARM_BIT];
          good = 1'b1;
          if (lb_header[7:4] == dev_addr) begin
            if (lb_header[ACK_BIT]) begin
              if (key_fill > 0) begin
                code   = {key_nibble(key_fifo[key_rd]), 4'h0};
                key_rd = (key_rd + 1) % KEY_QUEUE_DEPTH_DEF;
                key_fill--;
              end
              last_code = code;
            end else begin
              code = (last_code == NO_KEY) ? 8'h00 : last_code;
            end
            reply = 1'b1;
          end
          wrise      = w && !warn_seen;
          arise      = a && !alarm_seen;
          warn_seen  = w;
          alarm_seen = a;
        end
      end
    end
    n = reply ? 4 : 1;
    for (int k = 0; k < n; k++) begin
      e.has_reply      = reply;
      case (k)
        0:       e.reply_byte = reply ? head : 8'h00;
        1:       e.reply_byte = code;
        2:       e.reply_byte = 8'h00;
        default: e.reply_byte = head + code;
      endcase
      e.last           = (k == n - 1);
      e.packet_good    = (k == 0) && good;
      e.checksum_error = (k == 0) && cserr;
      e.overflow       = (k == 0) && ovf;
      e.warning_rise   = (k == 0) && wrise;
      e.alarm_rise     = (k == 0) && arise;
      e.key_dropped    = (k == 0) && drop;
      resp_due.push_back(e);
    end
  endtask

  task automatic send_word(input logic cmd, input logic [7:0] d);
    int gap;
    if (cmd || lb_in_frame || (lb_prev == 8'h00 && d != 8'h00)) useful++;
    in_valid <= 1'b1;
    command  <= cmd;
    data     <= d;
    do @(posedge clk); while (!in_ready);
    respond_to(cmd, d);
    gap     = draw_wait(in_calm);
    in_calm = next_calm(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (resp_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_device_id(input logic [3:0] v);
    settle();
    cfg_valid <= 1'b1;
    device_id <= v;
    do @(posedge clk); while (!cfg_ready);
    dev_addr = v;
    cfg_valid <= 1'b0;
  endtask

  // a packet can only start right after a zero on the line
  task automatic open_line();
    if (lb_in_frame || lb_prev != 8'h00) send_word(1'b0, 8'h00);
  endtask

  task automatic send_frame(input bit spoil);
    logic [7:0] total, chk;
    total = 8'h00;
    foreach (frame[i]) total = total + frame[i];
    if (total == 8'h00) total = 8'h01;
    chk = total;
    if (spoil) begin
      while (chk == total || chk == 8'h00) chk = 8'($urandom_range(1, 255));
    end
    open_line();
    foreach (frame[i]) send_word(1'b0, frame[i]);
    send_word(1'b0, chk);
    send_word(1'b0, 8'h00);
  endtask

  task automatic send_short(input logic [7:0] hdr);
    open_line();
    send_word(1'b0, hdr);
    send_word(1'b0, 8'h00);
  endtask

  task automatic send_runaway();
    open_line();
    repeat (MAX_PACKET_BYTES_DEF) send_word(1'b0, 8'($urandom_range(1, 255)));
  endtask

  function automatic logic [7:0] pick_key();
    if ($urandom_range(0, 5) == 0) return 8'($urandom_range(0, 255));
    return key_chars[$urandom_range(0, key_chars.len() - 1)];
  endfunction

  function automatic logic [7:0] random_header();
    logic [7:0] h;
    h[7:4] = ($urandom_range(0, 3) != 0) ? dev_addr : 4'($urandom_range(0, 15));
    h[3:0] = 4'($urandom_range(0, 15));
    if (h == 8'h00) h = 8'h04;
    return h;
  endfunction

  task automatic send_random_packet();
    int extra;
    frame = {};
    frame.push_back(random_header());
    if ($urandom_range(0, 9) != 0) frame.push_back(8'($urandom_range(1, 255)));
    extra = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 4);
    repeat (extra) frame.push_back(8'($urandom_range(1, 255)));
    send_frame($urandom_range(0, 9) == 0);
  endtask

  task automatic check_field(input string what, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s expected %h actual %h", $time, what, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (resp_due.size() == 0) begin
        $display("%0t result word expected none actual reply_byte %h last %b",
                 $time, reply_byte, last);
        errors++;
      end else begin
        want = resp_due.pop_front();
        check_field("has_reply", 8'(want.has_reply), 8'(has_reply));
        check_field("reply_byte", want.reply_byte, reply_byte);
        check_field("last", 8'(want.last), 8'(last));
        check_field("packet_good", 8'(want.packet_good), 8'(packet_good));
        check_field("checksum_error", 8'(want.checksum_error), 8'(checksum_error));
        check_field("overflow", 8'(want.overflow), 8'(overflow));
        check_field("warning_rise", 8'(want.warning_rise), 8'(warning_rise));
        check_field("alarm_rise", 8'(want.alarm_rise), 8'(alarm_rise));
        check_field("key_dropped", 8'(want.key_dropped), 8'(key_dropped));
      end
    end
  end

  initial begin
    int stall;
    out_ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall    = draw_wait(out_calm);
      out_calm = next_calm(out_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic test_repeat_after_reset();
    write_device_id(4'h0);
    frame = {8'h03, 8'h06};
    send_frame(1'b0);
  endtask

  task automatic test_empty_ack();
    frame = {8'h04, 8'h02};
    send_frame(1'b0);
  endtask

  task automatic test_key_codes();
    send_word(1'b1, "5");
    send_word(1'b1, 8'hFF);
    send_word(1'b1, 8'h00);
    frame = {8'h07, 8'h04};
    send_frame(1'b0);
    frame = {8'h04, 8'h01};
    send_frame(1'b0);
    frame = {8'h03, 8'h01};
    send_frame(1'b0);
    frame = {8'h0C, 8'hFF};
    send_frame(1'b0);
  endtask

  task automatic test_full_queue();
    repeat (KEY_QUEUE_DEPTH_DEF + 1) send_word(1'b1, pick_key());
  endtask

  task automatic test_short_packet();
    send_short(8'h01);
    send_short(8'h21);
  endtask

  task automatic test_bad_checksum();
    frame = {8'h04, 8'h06, 8'hFF};
    send_frame(1'b1);
  endtask

  task automatic test_frame_limits();
    frame = {8'h0C};
    repeat (MAX_PACKET_BYTES_DEF - 3) frame.push_back(8'hFF);
    send_frame(1'b0);
    send_runaway();
    send_word(1'b0, 8'h55);
    frame = {8'h04, 8'h80};
    send_frame(1'b0);
  endtask

  task automatic test_idle_framing();
    repeat (3) send_word(1'b0, 8'h00);
    send_word(1'b0, 8'hAA);
    send_word(1'b0, 8'hBB);
  endtask

  task automatic test_top_address();
    write_device_id(4'hF);
    send_word(1'b1, "#");
    frame = {8'hF4, 8'hF9};
    send_frame(1'b0);
    frame = {8'hF3, 8'h80};
    send_frame(1'b0);
    frame = {8'h14, 8'h06};
    send_frame(1'b0);
  endtask

  task automatic test_random_traffic();
    int goal;
    int pick;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       write_device_id(4'hF);
        1:       write_device_id(4'h0);
        default: write_device_id(4'($urandom_range(1, 14)));
      endcase
      goal = useful + 60;
      while (useful < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 58) begin
          send_random_packet();
        end else if (pick < 80) begin
          send_word(1'b1, pick_key());
        end else if (pick < 83) begin
          repeat ($urandom_range(8, 12)) send_word(1'b1, pick_key());
        end else if (pick < 92) begin
          send_word(1'b0, ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
        end else if (pick < 97) begin
          send_short(($urandom_range(0, 1) == 0) ? 8'h01 : random_header());
        end else begin
          send_runaway();
        end
      end
    end
  endtask

  initial begin
    clk         = 1'b0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    command     = 1'b0;
    data        = 8'h00;
    cfg_valid   = 1'b0;
    device_id   = 4'h0;
    lb_in_frame = 1'b0;
    lb_prev     = LINE_RESET;
    lb_count    = 6'd0;
    lb_header   = 8'h00;
    lb_status   = 8'h00;
    lb_tail     = 8'h00;
    lb_sum      = 8'h00;
    last_code   = NO_KEY;
    warn_seen   = 1'b0;
    alarm_seen  = 1'b0;
    key_fill    = 0;
    key_rd      = 0;
    dev_addr    = 4'h0;
    errors      = 0;
    useful      = 0;
    cycles      = 0;
    in_calm     = 0;
    out_calm    = 0;
    key_chars   = "0123456789f*v#p+yY\r";
    foreach (key_fifo[i]) key_fifo[i] = 8'h00;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_repeat_after_reset();
    test_empty_ack();
    test_key_codes();
    test_full_queue();
    test_short_packet();
    test_bad_checksum();
    test_frame_limits();
    test_idle_framing();
    test_top_address();
    test_random_traffic();
    settle();
    repeat (20) @(posedge clk);
    if (errors == 0 && resp_due.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
